>>> rtl/core/vpy_pkg.sv
package vpy_pkg;

    // Component and datapath widths.
    localparam int COMP_W          = 24;
    localparam int PRESHIFT        = 28;
    localparam int DATA_W          = COMP_W + PRESHIFT + 4;
    localparam int ANG_FRAC        = 24;
    localparam int ANG_W           = 34;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int OUT_W           = 21;
    localparam int ATAN_N          = 32;

    // Limit gain of the CORDIC in Q30.
    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

    // Angles in units of 2^-24 degree.
    localparam logic signed [ANG_W-1:0] DEG_180 = 34'sd3019898880;
    localparam logic signed [ANG_W-1:0] DEG_360 = 34'sd6039797760;

    // A full turn in output units.
    localparam int FULL_TURN_OUT = 360 << ANGLE_FRAC_BITS;

    // atan(2^-i) in units of 2^-24 degree, rounded to nearest.
    localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_N] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115,
        34'sd57,        34'sd29,        34'sd14,        34'sd7,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } t_vpy_in;

    typedef struct packed {
        logic [OUT_W-1:0] pitch_deg;
        logic [OUT_W-1:0] yaw_deg;
    } t_vpy_out;

    // Working vector and accumulated angle of one CORDIC cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ANG_W-1:0]  ang;
    } t_vpy_cstate;

    // Special-case flags that ride along with a request.
    typedef struct packed {
        logic zero;
        logic z_pos;
    } t_vpy_flags;

endpackage

>>> rtl/core/vpy_prep.sv
module vpy_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  vpy_pkg::t_vpy_in                    i_req,
    output logic                                o_valid,
    output vpy_pkg::t_vpy_cstate                o_state,
    output logic signed [vpy_pkg::DATA_W-1:0]   o_zg,
    output vpy_pkg::t_vpy_flags                 o_flags
);

    localparam int DW = vpy_pkg::DATA_W;
    localparam int CW = vpy_pkg::COMP_W;

    logic signed [DW-1:0]   w_x;
    logic signed [DW-1:0]   w_y;
    logic signed [CW:0]     w_zx;
    logic signed [CW:0]     w_neg_z;
    logic signed [DW-1:0]   w_prod;
    vpy_pkg::t_vpy_cstate   n_state;
    vpy_pkg::t_vpy_flags    n_flags;

    logic                   r_valid;
    vpy_pkg::t_vpy_cstate   r_state;
    logic signed [DW-1:0]   r_prod;
    vpy_pkg::t_vpy_flags    r_flags;

    // Sign-extend and scale the horizontal components.
    assign w_x = {{(DW-CW){i_req.vec_x[CW-1]}}, i_req.vec_x} <<< vpy_pkg::PRESHIFT;
    assign w_y = {{(DW-CW){i_req.vec_y[CW-1]}}, i_req.vec_y} <<< vpy_pkg::PRESHIFT;

    // Negated z times the CORDIC gain; the quarter scale is applied after the register.
    assign w_zx    = {i_req.vec_z[CW-1], i_req.vec_z};
    assign w_neg_z = -w_zx;
    assign w_prod  = DW'(w_neg_z) * DW'(vpy_pkg::GAIN_Q30);

    // Fold the left half plane onto the right half by a half turn.
    always_comb begin
        if (w_x[DW-1]) begin
            n_state.x   = -w_x;
            n_state.y   = -w_y;
            n_state.ang = vpy_pkg::DEG_180;
        end else begin
            n_state.x   = w_x;
            n_state.y   = w_y;
            n_state.ang = '0;
        end
        n_flags.zero  = (i_req.vec_x == '0) && (i_req.vec_y == '0);
        n_flags.z_pos = !i_req.vec_z[CW-1] && (i_req.vec_z != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_prod  <= w_prod;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_zg    = r_prod >>> 2;
    assign o_flags = r_flags;

endmodule

>>> rtl/core/vpy_cordic_cell.sv
module vpy_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  vpy_pkg::t_vpy_cstate    i_state,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output vpy_pkg::t_vpy_cstate    o_state,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int DW = vpy_pkg::DATA_W;
    localparam logic signed [vpy_pkg::ANG_W-1:0] L_ATAN = vpy_pkg::ATAN_TAB[SHIFT];

    logic signed [DW-1:0]   w_x;
    logic signed [DW-1:0]   w_y;
    logic signed [DW-1:0]   w_dx;
    logic signed [DW-1:0]   w_dy;
    vpy_pkg::t_vpy_cstate   n_state;

    logic                   r_valid;
    vpy_pkg::t_vpy_cstate   r_state;
    logic [SIDE_W-1:0]      r_side;

    assign w_x  = i_state.x;
    assign w_y  = i_state.y;
    assign w_dx = w_y >>> SHIFT;
    assign w_dy = w_x >>> SHIFT;

    // One vectoring step: rotate toward the x axis.
    always_comb begin
        if (!w_y[DW-1]) begin
            n_state.x   = w_x + w_dx;
            n_state.y   = w_y - w_dy;
            n_state.ang = i_state.ang + L_ATAN;
        end else begin
            n_state.x   = w_x - w_dx;
            n_state.y   = w_y + w_dy;
            n_state.ang = i_state.ang - L_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_side  = r_side;

endmodule

>>> rtl/core/vpy_finish.sv
module vpy_finish (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [vpy_pkg::ANG_W-1:0]    i_pitch,
    input  logic signed [vpy_pkg::ANG_W-1:0]    i_yaw,
    input  vpy_pkg::t_vpy_flags                 i_flags,
    output logic                                o_valid,
    output vpy_pkg::t_vpy_out                   o_res
);

    localparam int AW     = vpy_pkg::ANG_W;
    localparam int OW     = vpy_pkg::OUT_W;
    localparam int RSHIFT = vpy_pkg::ANG_FRAC - vpy_pkg::ANGLE_FRAC_BITS;
    localparam int ROUND  = 1 << (RSHIFT - 1);
    localparam logic [OW-1:0] PITCH_UP   = OW'(270 << vpy_pkg::ANGLE_FRAC_BITS);
    localparam logic [OW-1:0] PITCH_DOWN = OW'(90 << vpy_pkg::ANGLE_FRAC_BITS);

    logic signed [AW-1:0]   w_pitch_wrap;
    logic signed [AW-1:0]   w_yaw_wrap;

    logic                   r_valid;
    logic [AW-2:0]          r_pitch;
    logic [AW-2:0]          r_yaw;
    vpy_pkg::t_vpy_flags    r_flags;

    // Round a wrapped angle to output units; a round up to a full turn is zero.
    function automatic logic [OW-1:0] round_angle(input logic [AW-2:0] a);
        logic [AW-1:0] sum;
        logic [AW-1:0] q;
        sum = {1'b0, a} + AW'(ROUND);
        q   = sum >> RSHIFT;
        if (q >= AW'(vpy_pkg::FULL_TURN_OUT)) begin
            q = '0;
        end
        return q[OW-1:0];
    endfunction

    // Bring negative angles into [0, 360).
    assign w_pitch_wrap = i_pitch[AW-1] ? i_pitch + vpy_pkg::DEG_360 : i_pitch;
    assign w_yaw_wrap   = i_yaw[AW-1]   ? i_yaw   + vpy_pkg::DEG_360 : i_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pitch <= w_pitch_wrap[AW-2:0];
            r_yaw   <= w_yaw_wrap[AW-2:0];
            r_flags <= i_flags;
        end
    end

    // A vector with no horizontal length points straight up or down.
    always_comb begin
        if (r_flags.zero) begin
            o_res.pitch_deg = r_flags.z_pos ? PITCH_UP : PITCH_DOWN;
            o_res.yaw_deg   = '0;
        end else begin
            o_res.pitch_deg = round_angle(r_pitch);
            o_res.yaw_deg   = round_angle(r_yaw);
        end
    end

    assign o_valid = r_valid;

endmodule

>>> rtl/core/vector_to_pitch_yaw_unit.sv
// Channel   Valid        Ready         Request
// input     i_in_valid   o_in_ready    i_in_req  (vec_x, vec_y, vec_z)
// output    o_out_valid  i_out_ready   o_out_req (pitch_deg, yaw_deg)
//
// One request is taken per cycle while o_in_ready is high; it passes in order through
// one input stage, a row of yaw cells, a row of pitch cells, a wrap stage and the output.
// Each cell does one vectoring step, so the row takes one vector a cycle while it is not held.
// Reset is synchronous and clears only the valid bits of every stage.
// A stalled output fills a one-entry skid register; only then is o_in_ready dropped
// and the whole row holds.
module vector_to_pitch_yaw_unit #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vpy_pkg::t_vpy_in    i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vpy_pkg::t_vpy_out   o_out_req
);

    localparam int DW      = vpy_pkg::DATA_W;
    localparam int AW      = vpy_pkg::ANG_W;
    localparam int FW      = $bits(vpy_pkg::t_vpy_flags);
    localparam int YSIDE_W = DW + FW;
    localparam int PSIDE_W = AW + FW;

    logic                   w_en;
    logic                   w_prep_valid;
    vpy_pkg::t_vpy_cstate   w_prep_state;
    logic signed [DW-1:0]   w_prep_zg;
    vpy_pkg::t_vpy_flags    w_prep_flags;

    logic                   w_yvalid [CORDIC_STAGES+1];
    vpy_pkg::t_vpy_cstate   w_ystate [CORDIC_STAGES+1];
    logic [YSIDE_W-1:0]     w_yside  [CORDIC_STAGES+1];
    logic                   w_pvalid [CORDIC_STAGES+1];
    vpy_pkg::t_vpy_cstate   w_pstate [CORDIC_STAGES+1];
    logic [PSIDE_W-1:0]     w_pside  [CORDIC_STAGES+1];

    logic                   w_fin_valid;
    vpy_pkg::t_vpy_out      w_fin_res;
    logic                   w_out_fire;
    logic                   w_out_free;

    logic                   r_out_valid;
    logic                   n_out_valid;
    vpy_pkg::t_vpy_out      r_out_req;
    vpy_pkg::t_vpy_out      n_out_req;
    logic                   r_skid_valid;
    logic                   n_skid_valid;
    vpy_pkg::t_vpy_out      r_skid_req;
    vpy_pkg::t_vpy_out      n_skid_req;

    // The row advances whenever the skid register is empty.
    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // Input stage: scaling, half-turn fold and the z gain product.
    vpy_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_valid (w_prep_valid),
        .o_state (w_prep_state),
        .o_zg    (w_prep_zg),
        .o_flags (w_prep_flags)
    );

    assign w_yvalid[0] = w_prep_valid;
    assign w_ystate[0] = w_prep_state;
    assign w_yside[0]  = {w_prep_zg, w_prep_flags};

    // Yaw cells drive y to zero; the gain-scaled z rides along.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_yaw
        vpy_cordic_cell #(
            .SHIFT  (g),
            .SIDE_W (YSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_yvalid[g]),
            .i_state (w_ystate[g]),
            .i_side  (w_yside[g]),
            .o_valid (w_yvalid[g+1]),
            .o_state (w_ystate[g+1]),
            .o_side  (w_yside[g+1])
        );
    end

    // Pitch pass starts from the horizontal length and the scaled z; yaw rides along.
    assign w_pvalid[0]     = w_yvalid[CORDIC_STAGES];
    assign w_pstate[0].x   = w_ystate[CORDIC_STAGES].x;
    assign w_pstate[0].y   = w_yside[CORDIC_STAGES][YSIDE_W-1:FW];
    assign w_pstate[0].ang = '0;
    assign w_pside[0]      = {w_ystate[CORDIC_STAGES].ang, w_yside[CORDIC_STAGES][FW-1:0]};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
        vpy_cordic_cell #(
            .SHIFT  (g),
            .SIDE_W (PSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_pvalid[g]),
            .i_state (w_pstate[g]),
            .i_side  (w_pside[g]),
            .o_valid (w_pvalid[g+1]),
            .o_state (w_pstate[g+1]),
            .o_side  (w_pside[g+1])
        );
    end

    // Wrap, round and special cases.
    vpy_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pvalid[CORDIC_STAGES]),
        .i_pitch (w_pstate[CORDIC_STAGES].ang),
        .i_yaw   (w_pside[CORDIC_STAGES][PSIDE_W-1:FW]),
        .i_flags (vpy_pkg::t_vpy_flags'(w_pside[CORDIC_STAGES][FW-1:0])),
        .o_valid (w_fin_valid),
        .o_res   (w_fin_res)
    );

    // Output register with a one-entry skid behind it.
    assign w_out_fire = r_out_valid && i_out_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_req    = r_out_req;
        n_skid_valid = r_skid_valid;
        n_skid_req   = r_skid_req;
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_req    = r_skid_req;
                n_skid_valid = 1'b0;
            end
        end else if (w_fin_valid) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_req   = w_fin_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_req   = w_fin_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req  <= n_out_req;
        r_skid_req <= n_skid_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

>>> rtl/core/vpy_checker.sv
module vpy_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  vpy_pkg::t_vpy_out   o_out_req
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("result changed while stalled");

    // Both angles are always below a full turn.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.pitch_deg < vpy_pkg::OUT_W'(vpy_pkg::FULL_TURN_OUT))
                     && (o_out_req.yaw_deg < vpy_pkg::OUT_W'(vpy_pkg::FULL_TURN_OUT)))
        else $error("angle out of range");

    // Input back-pressure only comes from a full output side.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // The block is ready right after reset.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_ready)
        else $error("not ready after reset");

endmodule

bind vector_to_pitch_yaw_unit vpy_checker u_vpy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
